>>> rtl/sysex_parameter_message_framer_core_defines.svh
// assertion macros shared by the framer rtl
// depends on aclk and aresetn being visible where a macro is used
`ifndef SYSEX_PARAMETER_MESSAGE_FRAMER_CORE_DEFINES_SVH
`define SYSEX_PARAMETER_MESSAGE_FRAMER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SXF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SXF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sxf_pkg.sv
// shared types and constants of the sysex parameter message framer
// no dependencies
package sxf_pkg;

    // input opcodes
    localparam logic [1:0] OP_WSTART = 2'd0;
    localparam logic [1:0] OP_WDATA  = 2'd1;
    localparam logic [1:0] OP_REQ    = 2'd2;

    // error codes on the result channel
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_LEN  = 2'd1;
    localparam logic [1:0] ERR_SEQ  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODEL_ID  = 2'd1;
    localparam logic [6:0]  DEVICE_ID_RST = 7'd16;
    localparam logic [15:0] MODEL_ID_RST  = 16'd107;

    // message bytes
    localparam logic [7:0] BYTE_SOX     = 8'hF0;
    localparam logic [7:0] BYTE_EOX     = 8'hF7;
    localparam logic [7:0] BYTE_MAKER   = 8'h41;
    localparam logic [7:0] BYTE_CMD_SET = 8'h12;
    localparam logic [7:0] BYTE_CMD_REQ = 8'h11;

    // bytes added to the length for the frame limit check
    localparam logic [32:0] WRITE_OVERHEAD = 33'd12;
    localparam logic [32:0] REQ_OVERHEAD   = 33'd16;

    // byte positions inside a full message
    localparam logic [3:0] POS_SOX   = 4'd0;
    localparam logic [3:0] POS_MAKER = 4'd1;
    localparam logic [3:0] POS_DEV   = 4'd2;
    localparam logic [3:0] POS_MODH  = 4'd3;
    localparam logic [3:0] POS_MODL  = 4'd4;
    localparam logic [3:0] POS_CMD   = 4'd5;
    localparam logic [3:0] POS_ADR3  = 4'd6;
    localparam logic [3:0] POS_ADR2  = 4'd7;
    localparam logic [3:0] POS_ADR1  = 4'd8;
    localparam logic [3:0] POS_ADR0  = 4'd9;
    localparam logic [3:0] POS_SIZ3  = 4'd10;
    localparam logic [3:0] POS_SIZ2  = 4'd11;
    localparam logic [3:0] POS_SIZ1  = 4'd12;
    localparam logic [3:0] POS_SIZ0  = 4'd13;
    localparam logic [3:0] POS_CHK   = 4'd14;
    localparam logic [3:0] POS_EOX   = 4'd15;

    typedef enum logic [1:0] {
        K_FAIL,
        K_WSTART,
        K_DATA,
        K_REQ
    } kind_t;

    // one job handed from the front to the back
    typedef struct packed {
        kind_t       kind;
        logic [1:0]  err;
        logic        close;  // message ends with checksum and end byte
        logic [31:0] addr;
        logic [7:0]  val;    // payload byte, or low size byte of a request
        logic [6:0]  chk;
    } cmd_t;

endpackage

>>> rtl/sxf_front.sv
// front end: accepts items, tracks the open write message, builds jobs
// depends on sxf_pkg
module sxf_front #(
    parameter int FRAME_BYTES = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        opcode,
    input  logic [31:0]       address,
    input  logic [31:0]       length,
    input  logic [7:0]        data_byte,
    input  logic              q_full,
    output logic              q_push,
    output sxf_pkg::cmd_t     q_cmd
);

    localparam int LEFT_W = $clog2(FRAME_BYTES);
    localparam logic [32:0] FRAME_LIM = 33'(FRAME_BYTES);

    logic              in_msg_reg, in_msg_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic [6:0]        sum_reg, sum_next;

    logic              take;
    logic [6:0]        addr_sum;
    logic [6:0]        req_sum;
    logic [6:0]        data_sum;
    logic              too_long_w;
    logic              too_long_r;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    assign addr_sum   = address[30:24] + address[22:16] + address[14:8] + address[6:0];
    assign req_sum    = addr_sum + length[30:24] + length[22:16] + length[14:8] + length[6:0];
    assign data_sum   = sum_reg + data_byte[6:0];
    assign too_long_w = ({1'b0, length} + sxf_pkg::WRITE_OVERHEAD) > FRAME_LIM;
    assign too_long_r = ({1'b0, length} + sxf_pkg::REQ_OVERHEAD) > FRAME_LIM;

    always_comb begin
        in_msg_next  = in_msg_reg;
        left_next    = left_reg;
        sum_next     = sum_reg;
        q_push       = 1'b0;
        q_cmd.kind   = sxf_pkg::K_FAIL;
        q_cmd.err    = sxf_pkg::ERR_NONE;
        q_cmd.close  = 1'b1;
        q_cmd.addr   = address;
        q_cmd.val    = data_byte;
        q_cmd.chk    = 7'd0 - addr_sum;
        if (take) begin
            unique case (opcode)
                sxf_pkg::OP_WSTART: begin
                    q_push = 1'b1;
                    if (too_long_w) begin
                        q_cmd.err = sxf_pkg::ERR_LEN;
                    end else begin
                        q_cmd.kind  = sxf_pkg::K_WSTART;
                        q_cmd.close = (length == 32'd0);
                        if (length == 32'd0) begin
                            in_msg_next = 1'b0;
                            left_next   = '0;
                            sum_next    = 7'd0;
                        end else begin
                            in_msg_next = 1'b1;
                            left_next   = length[LEFT_W-1:0];
                            sum_next    = addr_sum;
                        end
                    end
                end
                sxf_pkg::OP_WDATA: begin
                    q_push = 1'b1;
                    if (!in_msg_reg) begin
                        q_cmd.err = sxf_pkg::ERR_SEQ;
                    end else begin
                        q_cmd.kind  = sxf_pkg::K_DATA;
                        q_cmd.chk   = 7'd0 - data_sum;
                        left_next   = left_reg - LEFT_W'(1);
                        q_cmd.close = (left_next == '0);
                        if (left_next == '0) begin
                            in_msg_next = 1'b0;
                            sum_next    = 7'd0;
                        end else begin
                            sum_next = data_sum;
                        end
                    end
                end
                sxf_pkg::OP_REQ: begin
                    q_push = 1'b1;
                    if (too_long_r) begin
                        q_cmd.err = sxf_pkg::ERR_LEN;
                    end else begin
                        q_cmd.kind  = sxf_pkg::K_REQ;
                        q_cmd.val   = length[7:0];
                        q_cmd.chk   = 7'd0 - req_sum;
                        in_msg_next = 1'b0;
                        left_next   = '0;
                        sum_next    = 7'd0;
                    end
                end
                default: begin
                    // unused opcode: swallowed, no job
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_msg_reg <= 1'b0;
            left_reg   <= '0;
            sum_reg    <= 7'd0;
        end else begin
            in_msg_reg <= in_msg_next;
            left_reg   <= left_next;
            sum_reg    <= sum_next;
        end
    end

endmodule

>>> rtl/sxf_queue.sv
// small job queue between the front and the back end
// depends on sxf_pkg
module sxf_queue #(
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sxf_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output sxf_pkg::cmd_t head_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sxf_pkg::cmd_t      mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/sxf_back.sv
// back end: expands each job into message bytes into the output register
// depends on sxf_pkg
module sxf_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [6:0]    device_id,
    input  logic [15:0]   model_id,
    input  logic          q_valid,
    input  sxf_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          out_last,
    output logic [1:0]    out_err
);

    logic          busy_reg, busy_next;
    logic          vld_reg, vld_next;
    sxf_pkg::cmd_t cur_reg, cur_next;
    logic [3:0]    pos_reg, pos_next;
    logic [7:0]    byte_reg;
    logic          last_reg;
    logic [1:0]    err_reg;

    logic          slot_free;
    logic          emit;
    logic          cur_last;
    logic [7:0]    cur_byte;
    logic [3:0]    pos_step;

    assign slot_free = !vld_reg || out_ready;
    assign emit      = busy_reg && slot_free;
    assign q_pop     = q_valid && (!busy_reg || (emit && cur_last));

    // byte at the current position and whether it ends the job
    always_comb begin
        cur_last = 1'b0;
        pos_step = pos_reg + 4'd1;
        unique case (cur_reg.kind)
            sxf_pkg::K_FAIL:   cur_last = 1'b1;
            sxf_pkg::K_WSTART: begin
                cur_last = (pos_reg == sxf_pkg::POS_EOX) ||
                           (pos_reg == sxf_pkg::POS_ADR0 && !cur_reg.close);
                if (pos_reg == sxf_pkg::POS_ADR0) pos_step = sxf_pkg::POS_CHK;
            end
            sxf_pkg::K_DATA: begin
                cur_last = (pos_reg == sxf_pkg::POS_EOX) ||
                           (pos_reg == sxf_pkg::POS_SIZ3 && !cur_reg.close);
                if (pos_reg == sxf_pkg::POS_SIZ3) pos_step = sxf_pkg::POS_CHK;
            end
            sxf_pkg::K_REQ:    cur_last = (pos_reg == sxf_pkg::POS_EOX);
        endcase

        case (pos_reg)
            sxf_pkg::POS_SOX:   cur_byte = sxf_pkg::BYTE_SOX;
            sxf_pkg::POS_MAKER: cur_byte = sxf_pkg::BYTE_MAKER;
            sxf_pkg::POS_DEV:   cur_byte = {1'b0, device_id};
            sxf_pkg::POS_MODH:  cur_byte = model_id[15:8];
            sxf_pkg::POS_MODL:  cur_byte = model_id[7:0];
            sxf_pkg::POS_CMD:   cur_byte = (cur_reg.kind == sxf_pkg::K_REQ) ?
                                           sxf_pkg::BYTE_CMD_REQ : sxf_pkg::BYTE_CMD_SET;
            sxf_pkg::POS_ADR3:  cur_byte = cur_reg.addr[31:24];
            sxf_pkg::POS_ADR2:  cur_byte = cur_reg.addr[23:16];
            sxf_pkg::POS_ADR1:  cur_byte = cur_reg.addr[15:8];
            sxf_pkg::POS_ADR0:  cur_byte = cur_reg.addr[7:0];
            sxf_pkg::POS_SIZ3:  cur_byte = (cur_reg.kind == sxf_pkg::K_DATA) ?
                                           cur_reg.val : 8'd0;
            sxf_pkg::POS_SIZ0:  cur_byte = cur_reg.val;
            sxf_pkg::POS_CHK:   cur_byte = {1'b0, cur_reg.chk};
            sxf_pkg::POS_EOX:   cur_byte = sxf_pkg::BYTE_EOX;
            default:            cur_byte = 8'd0;
        endcase
        if (cur_reg.kind == sxf_pkg::K_FAIL) cur_byte = 8'd0;
    end

    always_comb begin
        busy_next = busy_reg;
        cur_next  = cur_reg;
        pos_next  = pos_reg;
        vld_next  = vld_reg;
        if (slot_free) vld_next = busy_reg;
        if (emit) begin
            pos_next = pos_step;
            if (cur_last) busy_next = 1'b0;
        end
        if (q_pop) begin
            busy_next = 1'b1;
            cur_next  = q_cmd;
            pos_next  = (q_cmd.kind == sxf_pkg::K_DATA) ? sxf_pkg::POS_SIZ3 : sxf_pkg::POS_SOX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            vld_reg  <= 1'b0;
            cur_reg  <= '0;
            pos_reg  <= sxf_pkg::POS_SOX;
        end else begin
            busy_reg <= busy_next;
            vld_reg  <= vld_next;
            cur_reg  <= cur_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            byte_reg <= cur_byte;
            last_reg <= cur_last;
            err_reg  <= cur_reg.err;
        end
    end

    assign out_valid = vld_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_err   = err_reg;

endmodule

>>> rtl/sysex_parameter_message_framer_core.sv
// top level of the sysex parameter message framer
// depends on sxf_pkg, sxf_front, sxf_queue, sxf_back and the defines header
//
// usage:
//   s_ channel takes one command word: s_tuser is the opcode (write start,
//   write data, read request), s_tdata carries address, length and data byte.
//   m_ channel gives the framed message one byte per word; m_tlast marks the
//   final byte caused by a command word, m_tuser is its error code.
//   cfg_ channel writes device id (index 0) and model id (index 1); it is
//   always ready; the user must write it only while the block is idle, which the block itself does not enforce.
// path: with empty queues the first byte of an accepted word passes the job queue,
//   the back end's job register and the output register before it is valid.
// throughput: the back end sends one byte per cycle while m_tready is high; a
//   word causes 1 to 16 bytes (a read request 16); the front end takes a word
//   every cycle while the job queue has room, so short words run back to
//   back.
// reset: aresetn low clears the open message, the queue and the output
//   register, and sets device id 16 and model id 107.
// stall: a low m_tready holds the output word; the back end stops, the queue
//   fills, and s_tready drops only once the queue is full.
`include "sysex_parameter_message_framer_core_defines.svh"

module sysex_parameter_message_framer_core #(
    parameter int FRAME_BYTES = 128,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [71:0]                    s_tdata,   // address, length, data_byte
    input  logic [1:0]                     s_tuser,   // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // out_byte
    output logic                           m_tlast,
    output logic [1:0]                     m_tuser,   // error
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sxf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sxf_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

    // configuration registers
    logic [6:0]    device_id_reg;
    logic [15:0]   model_id_reg;

    // front to queue to back
    logic          q_push;
    logic          q_full;
    sxf_pkg::cmd_t q_push_cmd;
    logic          q_pop;
    logic          q_head_valid;
    sxf_pkg::cmd_t q_head_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_id_reg <= sxf_pkg::DEVICE_ID_RST;
            model_id_reg  <= sxf_pkg::MODEL_ID_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                sxf_pkg::CFG_DEVICE_ID: device_id_reg <= cfg_wdata[6:0];
                sxf_pkg::CFG_MODEL_ID:  model_id_reg  <= cfg_wdata[15:0];
                default: begin
                    // writes beyond the register list are dropped
                    device_id_reg <= device_id_reg;
                end
            endcase
        end
    end

    // front: decode, range checks, open-message state, checksum
    sxf_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .opcode    (s_tuser),
        .address   (s_tdata[31:0]),
        .length    (s_tdata[63:32]),
        .data_byte (s_tdata[71:64]),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_push_cmd)
    );

    // job queue lets the front keep taking words while bytes drain
    sxf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // back: byte sequencer with the output register
    sxf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .device_id (device_id_reg),
        .model_id  (model_id_reg),
        .q_valid   (q_head_valid),
        .q_cmd     (q_head_cmd),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_err   (m_tuser)
    );

    // a job is never pushed into a full queue
    `SXF_ASSERT_NOW(a_queue_no_overflow, q_push, !q_full, "job pushed into full queue")
    // an error word is always a single-byte, last word
    `SXF_ASSERT_NOW(a_error_is_last, m_tvalid && (m_tuser != sxf_pkg::ERR_NONE), m_tlast, "error word without tlast")
    // bytes of one burst follow without gaps
    `SXF_ASSERT_NEXT(a_burst_gapless, m_tvalid && m_tready && !m_tlast, m_tvalid, "gap inside a message burst")

endmodule
